FILE: rtl/rsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_pkg: shared types and constants of the range scaler
// Register indexes, reset values, the job word passed from the front end to
// the back end, and a magnitude helper.
// ----------------------------------------------------------------------------
package rsa_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned CfgIdxW = 3;
    // quotient bits produced by the divider; anything at or above 2^33
    // saturates after the offset add, so 34 bits are enough
    localparam int unsigned QuoW = 34;
    localparam int unsigned ProdW = 2 * DataW;
    localparam int unsigned CntW = 6;

    typedef enum logic [CfgIdxW-1:0] {
        REG_MIN_IN     = 3'd0,
        REG_MAX_IN     = 3'd1,
        REG_MIN_OUT    = 3'd2,
        REG_MAX_OUT    = 3'd3,
        REG_CLAMP_ON   = 3'd4,
        REG_AUTO_RANGE = 3'd5
    } t_cfg_reg;

    localparam logic signed [DataW-1:0] RstMinIn  = 32'sd0;
    localparam logic signed [DataW-1:0] RstMaxIn  = 32'sd65536;      // 1.0
    localparam logic signed [DataW-1:0] RstMinOut = 32'sd0;
    localparam logic signed [DataW-1:0] RstMaxOut = 32'sd8323072;    // 127.0

    // one classified sample
    typedef struct packed {
        logic                    direct;    // result is base, no divide
        logic signed [DataW-1:0] base;      // direct result or output offset
        logic        [DataW-1:0] mag_a;     // |s - working_min|
        logic        [DataW-1:0] mag_b;     // |max_out - min_out|
        logic        [DataW-1:0] mag_d;     // |working span|
        logic                    neg;       // sign of the quotient
        logic                    span_zero;
        logic                    last;
    } t_job;

    // magnitude of a 33-bit signed value; below 2^32 for 32-bit differences
    function automatic logic [DataW-1:0] mag33(input logic signed [DataW:0] v);
        logic [DataW:0] m;
        m = v[DataW] ? (-v) : v;
        return m[DataW-1:0];
    endfunction

endpackage

FILE: rtl/rsa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_front: config registers, auto-range tracking and classification
// Each accepted word updates the working range and is turned into a job:
// either a direct result (clamp or zero span) or divide operands.
// ----------------------------------------------------------------------------
module rsa_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rsa_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [rsa_pkg::DataW-1:0]   i_cfg_data,
    input  logic                        i_accept,
    input  logic signed [rsa_pkg::DataW-1:0] i_sample,
    input  logic                        i_last_in,
    output rsa_pkg::t_job               o_job
);
    import rsa_pkg::*;

    logic signed [DataW-1:0] r_wmin, r_wmax, r_min_out, r_max_out;
    logic                    r_seen, r_clamp, r_auto;

    logic signed [DataW:0] s33, wmin33, wmax33, n_wmin, n_wmax;
    logic signed [DataW:0] span, a_diff, b_diff;
    logic                  hi, lo, zero;
    logic                  cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    assign s33    = {i_sample[DataW-1], i_sample};
    assign wmin33 = {r_wmin[DataW-1], r_wmin};
    assign wmax33 = {r_wmax[DataW-1], r_wmax};

    // auto-range update comes before the mapping
    always_comb begin
        n_wmax = wmax33;
        n_wmin = wmin33;
        if (r_auto && (s33 > wmax33 || !r_seen)) begin
            n_wmax = s33;
        end
        if (r_auto && (s33 < wmin33 || !r_seen)) begin
            n_wmin = s33;
        end
    end

    assign span   = n_wmax - n_wmin;
    assign zero   = (span == '0);
    assign hi     = r_clamp && (s33 > n_wmax);
    assign lo     = r_clamp && (s33 < n_wmin);
    assign a_diff = s33 - n_wmin;
    assign b_diff = {r_max_out[DataW-1], r_max_out} - {r_min_out[DataW-1], r_min_out};

    always_comb begin
        o_job.direct    = hi || lo || zero;
        o_job.base      = hi ? r_max_out : r_min_out;
        o_job.mag_a     = mag33(a_diff);
        o_job.mag_b     = mag33(b_diff);
        o_job.mag_d     = mag33(span);
        o_job.neg       = a_diff[DataW] ^ b_diff[DataW] ^ span[DataW];
        o_job.span_zero = zero;
        o_job.last      = i_last_in;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wmin    <= RstMinIn;
            r_wmax    <= RstMaxIn;
            r_min_out <= RstMinOut;
            r_max_out <= RstMaxOut;
            r_seen    <= 1'b0;
            r_clamp   <= 1'b1;
            r_auto    <= 1'b0;
        end else if (cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_MIN_IN:     r_wmin    <= i_cfg_data;
                REG_MAX_IN:     r_wmax    <= i_cfg_data;
                REG_MIN_OUT:    r_min_out <= i_cfg_data;
                REG_MAX_OUT:    r_max_out <= i_cfg_data;
                REG_CLAMP_ON:   r_clamp   <= i_cfg_data[0];
                REG_AUTO_RANGE: begin
                    r_auto <= i_cfg_data[0];
                    if (i_cfg_data[0]) begin
                        r_seen <= 1'b0;
                    end
                end
                default: ;
            endcase
        end else if (i_accept) begin
            r_wmin <= n_wmin[DataW-1:0];
            r_wmax <= n_wmax[DataW-1:0];
            if (r_auto) begin
                r_seen <= 1'b1;
            end
        end
    end

endmodule

FILE: rtl/rsa_jobq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_jobq: two-entry job queue
// Decouples the classifier from the divider.
// ----------------------------------------------------------------------------
module rsa_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rsa_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output rsa_pkg::t_job o_job
);
    import rsa_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule

FILE: rtl/rsa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_back: multiply, radix-2 divide, offset and saturate
// One job at a time; the result register is the output word.
// ----------------------------------------------------------------------------
module rsa_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_job_empty,
    input  rsa_pkg::t_job            i_job,
    output logic                     o_job_pop,
    output logic                     o_empty,
    input  logic                     i_pop,
    output logic signed [rsa_pkg::DataW-1:0] o_scaled,
    output logic                     o_span_zero,
    output logic                     o_last_out
);
    import rsa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_CHK  = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    localparam int unsigned SumW = QuoW + 2;

    t_state r_state, n_state;
    t_job   r_job;
    logic [ProdW-1:0] r_prod;
    logic [DataW-1:0] r_rem;
    logic [QuoW-1:0]  r_quo;     // low dividend bits, then quotient
    logic [CntW-1:0]  r_cnt;
    logic             r_valid;
    logic signed [DataW-1:0] r_scaled;
    logic             r_zero, r_last;

    logic [DataW:0]        rem_sh;
    logic                  q_bit;
    logic [DataW:0]        rem_sub;
    logic signed [SumW-1:0] base_x, quo_x, sum;
    logic signed [DataW-1:0] sat_val;
    logic                  slot_free;
    logic                  ovf;

    assign o_empty     = !r_valid;
    assign o_scaled    = r_scaled;
    assign o_span_zero = r_zero;
    assign o_last_out  = r_last;
    assign slot_free   = !r_valid || i_pop;
    assign o_job_pop   = (r_state == S_IDLE) && !i_job_empty;

    // quotient can reach 2^34 or more: forced to all ones, saturates anyway
    assign ovf = ({2'b00, r_prod[ProdW-1:QuoW]} >= r_job.mag_d);

    // one restoring step
    assign rem_sh  = {r_rem, r_quo[QuoW-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_job.mag_d});
    assign rem_sub = rem_sh - {1'b0, r_job.mag_d};

    // offset add and saturation
    assign base_x = SumW'(r_job.base);
    assign quo_x  = SumW'({1'b0, r_quo});
    assign sum    = r_job.neg ? (base_x - quo_x) : (base_x + quo_x);
    always_comb begin
        if (sum > SumW'(signed'({1'b0, {(DataW-1){1'b1}}}))) begin
            sat_val = {1'b0, {(DataW-1){1'b1}}};
        end else if (sum < -SumW'(signed'({1'b0, 1'b1, {(DataW-1){1'b0}}}))) begin
            sat_val = {1'b1, {(DataW-1){1'b0}}};
        end else begin
            sat_val = sum[DataW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    n_state = i_job.direct ? S_FIN : S_MUL;
                end
            end
            S_MUL:  n_state = S_CHK;
            S_CHK:  n_state = ovf ? S_FIN : S_DIV;
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
            end
            S_MUL: begin
                r_prod <= ProdW'(r_job.mag_a) * ProdW'(r_job.mag_b);
            end
            S_CHK: begin
                r_rem <= DataW'(r_prod[ProdW-1:QuoW]);
                r_quo <= ovf ? {QuoW{1'b1}} : r_prod[QuoW-1:0];
                r_cnt <= CntW'(QuoW - 1);
            end
            S_DIV: begin
                r_rem <= q_bit ? rem_sub[DataW-1:0] : rem_sh[DataW-1:0];
                r_quo <= {r_quo[QuoW-2:0], q_bit};
                r_cnt <= r_cnt - 1'b1;
            end
            default: ;
        endcase
        if ((r_state == S_FIN) && slot_free) begin
            r_scaled <= r_job.direct ? r_job.base : sat_val;
            r_zero   <= r_job.span_zero;
            r_last   <= r_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_FIN) && slot_free) begin
                r_valid <= 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: rtl/range_scaler_with_autorange.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_scaler_with_autorange: linear range mapping with auto-range
// Maps signed Q16.16 samples from the working input range to the output
// range, with clamping, auto-ranging and zero-span detection.
// ----------------------------------------------------------------------------
// Flow: each word waits in the job queue; the back end then loads it, and a
//   mapped word goes through multiply, overflow check, the 34-step radix-2
//   divide (skipped on overflow) and finish, while a clamped or zero-span
//   word goes straight to finish. The back end takes one job at a time, and
//   finish waits until the output word is free.
// Reset: synchronous, active low; registers return to their defaults, the
//   job queue and the output word are emptied.
module range_scaler_with_autorange (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config write channel
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rsa_pkg::CfgIdxW-1:0] i_cfg_index,
    input  logic [rsa_pkg::DataW-1:0]   i_cfg_data,
    // input queue side
    input  logic                        push,
    output logic                        full,
    input  logic signed [rsa_pkg::DataW-1:0] i_sample,
    input  logic                        i_last_in,
    // result queue side
    output logic                        empty,
    input  logic                        pop,
    output logic signed [rsa_pkg::DataW-1:0] o_scaled,
    output logic                        o_span_zero,
    output logic                        o_last_out
);
    import rsa_pkg::*;

    t_job front_job;   // classified word, straight from the front end
    t_job q_job;       // head of the job queue
    logic in_accept;
    logic q_empty;
    logic q_pop;

    // A word is taken whenever the job queue has room; the front end updates
    // the working range in that same cycle, if no config write comes with it.
    assign in_accept = push && !full;

    rsa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_sample    (i_sample),
        .i_last_in   (i_last_in),
        .o_job       (front_job)
    );

    // Two jobs of slack: the front keeps taking words while the divider runs
    // and while a finished word waits at the output.
    rsa_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    // Multiply, then long division one quotient bit per cycle, then offset
    // and saturate into the output word register.
    rsa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (q_empty),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_scaled    (o_scaled),
        .o_span_zero (o_span_zero),
        .o_last_out  (o_last_out)
    );

endmodule

FILE: rtl/rsa_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_check: port-level checks for the range scaler
// Tracks words in flight and checks queue flags against it.
// ----------------------------------------------------------------------------
module rsa_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              push,
    input logic                              full,
    input logic                              empty,
    input logic                              pop,
    input logic signed [rsa_pkg::DataW-1:0]  o_scaled
);
    import rsa_pkg::*;

    logic [2:0] r_inflight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 3'd0;
        end else begin
            r_inflight <= r_inflight + 3'(push && !full) - 3'(pop && !empty);
        end
    end

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> r_inflight != 3'd0)
        else $error("result word without a pending input word");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd4)
        else $error("more words in flight than storage holds");

    a_full_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> r_inflight >= 3'd2)
        else $error("full raised with job queue not full");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_scaled))
        else $error("waiting result word changed");

endmodule

bind range_scaler_with_autorange rsa_check u_rsa_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_scaled (o_scaled)
);

FILE: tb/range_scaler_with_autorange_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_scaler_with_autorange_tb: self-checking bench of the range scaler
// Drives sample words through the push/full side and pulls mapped words from
// the empty/pop side, with random idle bursts on both sides. Every accepted
// sample is mapped by a local integer model of the scaler, and each popped
// word is compared field by field with the oldest prediction. Settings are
// only changed while the scaler is drained.
// ----------------------------------------------------------------------------
module range_scaler_with_autorange_tb;

    import rsa_pkg::*;

    // Index values outside the register map; writes to them must do nothing.
    localparam logic [CfgIdxW-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_SPARE_7 = 3'd7;

    localparam int     One   = 65536;                  // 1.0 in Q16.16
    localparam longint SatHi = 64'sd2147483647;
    localparam longint SatLo = -64'sd2147483648;

    // One mapped word as it leaves the scaler.
    typedef struct packed {
        logic signed [DataW-1:0] scaled;
        logic                    span_zero;
        logic                    last;
    } t_scaled_word;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CfgIdxW-1:0]      cfg_index;
    logic [DataW-1:0]        cfg_data;
    logic                    push;
    logic                    full;
    logic signed [DataW-1:0] sample;
    logic                    last_in;
    logic                    empty;
    logic                    pop;
    logic signed [DataW-1:0] scaled;
    logic                    span_zero;
    logic                    last_out;

    // Mirror of the scaler's settings and auto-range state.
    longint wk_min;
    longint wk_max;
    longint out_lo;
    longint out_hi;
    bit     clamp_en;
    bit     auto_en;
    bit     seen_any;

    t_scaled_word pending_words[$];
    int           mismatch_count;
    bit           gaps_on;          // random idle bursts on both sides
    int           hold_off_req;     // asks the result side to stop popping

    range_scaler_with_autorange u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .push        (push),
        .full        (full),
        .i_sample    (sample),
        .i_last_in   (last_in),
        .empty       (empty),
        .pop         (pop),
        .o_scaled    (scaled),
        .o_span_zero (span_zero),
        .o_last_out  (last_out)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Mapping model. Auto-range tracking happens first, so the sample that
    // moves a bound is mapped inside the new range. The Q16.16 scales cancel,
    // so the whole mapping is plain integer math on magnitudes.
    // ------------------------------------------------------------------------
    function automatic t_scaled_word map_sample(input logic signed [DataW-1:0] s_in,
                                                input logic last);
        longint       s;
        longint       span;
        longint       res;
        longint       a;
        longint       b;
        bit           neg;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [63:0]  md;
        logic [63:0]  q;
        t_scaled_word w;
        s = longint'(s_in);
        if (auto_en) begin
            if (s > wk_max || !seen_any) wk_max = s;
            if (s < wk_min || !seen_any) wk_min = s;
            seen_any = 1'b1;
        end
        span = wk_max - wk_min;
        // clamp checks the upper bound first; matters for an inverted range
        if (clamp_en && s > wk_max) begin
            res = out_hi;
        end else if (clamp_en && s < wk_min) begin
            res = out_lo;
        end else if (span == 0) begin
            res = out_lo;
        end else begin
            a   = s - wk_min;
            b   = out_hi - out_lo;
            neg = (a < 0) != (b < 0);
            if (span < 0) neg = !neg;
            ma  = (a < 0) ? -a : a;
            mb  = (b < 0) ? -b : b;
            md  = (span < 0) ? -span : span;
            q   = (ma * mb) / md;               // truncates toward zero
            if (q > (64'd1 << 34)) q = 64'd1 << 34;
            res = neg ? -$signed(q) : $signed(q);
            res = res + out_lo;
            if (res > SatHi) res = SatHi;
            else if (res < SatLo) res = SatLo;
        end
        w.scaled    = res[DataW-1:0];
        w.span_zero = (span == 0);
        w.last      = last;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Tracks every handshake at the rising edge: config writes update the
    // model, accepted samples queue a prediction, popped words are checked.
    // The pop check runs before the push so a word can never be matched
    // against a sample taken in the same cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : track_and_compare
        t_scaled_word want;
        if (!rst_n) begin
            wk_min   = longint'(RstMinIn);
            wk_max   = longint'(RstMaxIn);
            out_lo   = longint'(RstMinOut);
            out_hi   = longint'(RstMaxOut);
            clamp_en = 1'b1;
            auto_en  = 1'b0;
            seen_any = 1'b0;
            pending_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MIN_IN:     wk_min = longint'($signed(cfg_data));
                    REG_MAX_IN:     wk_max = longint'($signed(cfg_data));
                    REG_MIN_OUT:    out_lo = longint'($signed(cfg_data));
                    REG_MAX_OUT:    out_hi = longint'($signed(cfg_data));
                    REG_CLAMP_ON:   clamp_en = cfg_data[0];
                    REG_AUTO_RANGE: begin
                        auto_en = cfg_data[0];
                        // enabling restarts tracking, even if already on
                        if (auto_en) seen_any = 1'b0;
                    end
                    default: ;      // unmapped index, ignored
                endcase
            end
            if (pop && !empty) begin
                if (pending_words.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %0d/%0b/%0b",
                             $time, scaled, span_zero, last_out);
                    mismatch_count++;
                end else begin
                    want = pending_words.pop_front();
                    if (scaled !== want.scaled) begin
                        $display("%0t: scaled mismatch, expected %0d, actual %0d",
                                 $time, want.scaled, scaled);
                        mismatch_count++;
                    end
                    if (span_zero !== want.span_zero) begin
                        $display("%0t: span_zero mismatch, expected %0b, actual %0b",
                                 $time, want.span_zero, span_zero);
                        mismatch_count++;
                    end
                    if (last_out !== want.last) begin
                        $display("%0t: last_out mismatch, expected %0b, actual %0b",
                                 $time, want.last, last_out);
                        mismatch_count++;
                    end
                end
            end
            if (push && !full) pending_words.push_back(map_sample(sample, last_in));
        end
    end

    // ------------------------------------------------------------------------
    // Result side: pops by default, with random stall bursts, and a long
    // hold-off when a test asks for one. The hold-off is counted here.
    // ------------------------------------------------------------------------
    initial begin : result_drain
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        pop        = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req != 0) begin
                hold_left    = hold_off_req;
                hold_off_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Push stays high from one word to the next unless an idle burst
    // is drawn; callers lower it with quiet_input when a batch is done.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic signed [DataW-1:0] value, input logic last);
        int gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        @(negedge clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push    <= 1'b1;
        sample  <= value;
        last_in <= last;
        do @(posedge clk); while (full);
    endtask

    task automatic quiet_input();
        @(negedge clk);
        push <= 1'b0;
    endtask

    // Wait until every predicted word has been popped; the scaler is idle then.
    task automatic drain_results();
        quiet_input();
        while (pending_words.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input logic [DataW-1:0] lo_in, input logic [DataW-1:0] hi_in,
                                 input logic [DataW-1:0] lo_out, input logic [DataW-1:0] hi_out,
                                 input logic [DataW-1:0] clamp, input logic [DataW-1:0] autor);
        write_reg(REG_AUTO_RANGE, autor);
        write_reg(REG_MIN_IN, lo_in);
        write_reg(REG_MAX_IN, hi_in);
        write_reg(REG_MIN_OUT, lo_out);
        write_reg(REG_MAX_OUT, hi_out);
        write_reg(REG_CLAMP_ON, clamp);
    endtask

    // Bound or output value: full random, round numbers, extremes, short ones.
    function automatic logic signed [DataW-1:0] pick_value();
        int                k;
        logic signed [15:0] h;
        k = $urandom_range(0, 400);
        h = 16'($urandom);
        case ($urandom_range(0, 4))
            0:       return $urandom;
            1:       return (k - 200) * One;
            2:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            3:       return h;
            default: return (k - 200) * 4096;
        endcase
    endfunction

    // Sample: mostly inside the current working range, plus its edges and noise.
    function automatic logic signed [DataW-1:0] pick_sample();
        longint lo;
        longint hi;
        lo = (wk_min < wk_max) ? wk_min : wk_max;
        hi = (wk_min < wk_max) ? wk_max : wk_min;
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return lo[DataW-1:0];
            3:       return hi[DataW-1:0];
            4:       return 32'(lo - 1);
            5:       return 32'(hi + 1);
            default: return 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Settings straight out of reset: 0..1.0 mapped onto 0..127.0, clamped.
    task automatic test_reset_defaults();
        send_word(0, 1'b0);
        send_word(One / 2, 1'b1);
        send_word(One, 1'b0);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b1);
    endtask

    // Clamp off with full-scale ranges: quotient and sum saturation.
    task automatic test_clamping_and_overflow();
        drain_results();
        write_reg(REG_CLAMP_ON, 32'hFFFF_FFFE);
        write_reg(REG_MIN_OUT, 32'h8000_0000);
        write_reg(REG_MAX_OUT, 32'h7FFF_FFFF);
        send_word(32'sh7FFF_FFFF, 1'b0);
        send_word(32'sh8000_0000, 1'b0);
        send_word(12345, 1'b1);
        drain_results();
        // unmapped indexes must leave everything alone
        write_reg(REG_SPARE_6, $urandom);
        write_reg(REG_SPARE_7, $urandom);
        send_word(-1, 1'b0);
        drain_results();
        write_reg(REG_MIN_IN, 32'h8000_0000);
        write_reg(REG_MAX_IN, 32'h7FFF_FFFF);
        send_word(0, 1'b1);
    endtask

    // Equal bounds: flag set, output bound or min_out depending on clamp.
    task automatic test_zero_span();
        drain_results();
        write_reg(REG_MIN_IN, 5 * One);
        write_reg(REG_MAX_IN, 5 * One);
        write_reg(REG_MIN_OUT, 0);
        write_reg(REG_MAX_OUT, 127 * One);
        write_reg(REG_CLAMP_ON, 32'hFFFF_0001);
        send_word(5 * One, 1'b0);
        send_word(7 * One, 1'b0);
        send_word(3 * One, 1'b1);
        drain_results();
        write_reg(REG_CLAMP_ON, 0);
        send_word(7 * One, 1'b0);
    endtask

    // min_in above max_in: clamp tests the upper bound first, mapping uses
    // the negative span.
    task automatic test_inverted_range();
        drain_results();
        write_reg(REG_MIN_IN, 10 * One);
        write_reg(REG_MAX_IN, -10 * One);
        write_reg(REG_CLAMP_ON, 1);
        send_word(0, 1'b0);
        send_word(-20 * One, 1'b1);
        drain_results();
        write_reg(REG_CLAMP_ON, 0);
        send_word(0, 1'b0);
        send_word(3 * One, 1'b1);
    endtask

    // First sample sets both bounds, later ones widen them; re-enabling
    // while already on restarts tracking.
    task automatic test_auto_range_directed();
        drain_results();
        write_reg(REG_AUTO_RANGE, 32'h0000_0003);
        send_word(100 * One, 1'b0);
        send_word(50 * One, 1'b0);
        send_word(200 * One, 1'b0);
        send_word(75 * One, 1'b1);
        drain_results();
        write_reg(REG_AUTO_RANGE, 1);
        send_word(1000, 1'b0);
        send_word(-7, 1'b1);
        drain_results();
        write_reg(REG_AUTO_RANGE, 32'hFFFF_FFFE);
    endtask

    // Fixed-range mapping under many settings, extremes first.
    task automatic test_random_mappings(input int phases, input int per_phase);
        for (int p = 0; p < phases; p++) begin
            drain_results();
            case (p)
                0: load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                 $urandom, $urandom & 32'hFFFF_FFFE);
                1: load_settings(-3 * One, -3 * One, pick_value(), pick_value(),
                                 $urandom, $urandom & 32'hFFFF_FFFE);
                2: load_settings(-One, 100 * One, 32'h8000_0000, 32'h7FFF_FFFF,
                                 0, 0);
                default: load_settings(pick_value(), pick_value(), pick_value(), pick_value(),
                                       $urandom, $urandom & 32'hFFFF_FFFE);
            endcase
            for (int i = 0; i < per_phase; i++)
                send_word(pick_sample(), 1'($urandom_range(0, 1)));
        end
    endtask

    // Auto-range lists: a drifting sample stream with the occasional outlier,
    // last set on the final word.
    task automatic test_auto_range_lists(input int lists, input int per_list);
        logic signed [DataW-1:0] centre;
        longint                  d;
        for (int l = 0; l < lists; l++) begin
            drain_results();
            load_settings(pick_value(), pick_value(), pick_value(), pick_value(),
                          $urandom, $urandom | 32'h1);
            // a bound written after enabling must be overruled by the first word
            if (l % 2 == 1) write_reg(REG_MIN_IN, pick_value());
            centre = pick_value();
            for (int i = 0; i < per_list; i++) begin
                d = longint'($urandom_range(0, 2 * One)) - One;
                if ($urandom_range(0, 9) == 0)
                    send_word(pick_value(), i == per_list - 1);
                else
                    send_word(32'(longint'(centre) + d * (i + 1)), i == per_list - 1);
            end
        end
        drain_results();
        write_reg(REG_AUTO_RANGE, 0);
    endtask

    // Result side holds off long enough for the scaler to fill and stall push.
    task automatic test_output_backpressure();
        drain_results();
        load_settings(-50 * One, 50 * One, -One, 1000 * One, 0, 0);
        hold_off_req = 400;
        for (int i = 0; i < 40; i++)
            send_word(pick_sample(), i == 39);
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_steady_stream(input int count);
        drain_results();
        gaps_on = 1'b0;
        load_settings(pick_value(), pick_value(), pick_value(), pick_value(), $urandom, 0);
        for (int i = 0; i < count; i++)
            send_word(pick_sample(), 1'($urandom_range(0, 1)));
    endtask

    initial begin : run_tests
        clk            = 1'b0;
        rst_n          = 1'b0;
        push           = 1'b0;
        sample         = '0;
        last_in        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        gaps_on        = 1'b1;
        hold_off_req   = 0;
        mismatch_count = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_clamping_and_overflow();
        test_zero_span();
        test_inverted_range();
        test_auto_range_directed();
        test_random_mappings(8, 165);
        test_auto_range_lists(3, 100);
        test_output_backpressure();
        test_steady_stream(150);

        // all words out, then a tail in case a stray word follows
        drain_results();
        repeat (60) @(negedge clk);
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
